@@ sv/okvt_pkg.sv @@
// Shared constants and types for the ordered key/value table.
package okvt_pkg;

  // Payload field widths on the channels
  localparam int KIND_W   = 3;
  localparam int KEY_W    = 32;
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 4;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 4;
  localparam int COUNT_W  = 5;

  // Operation codes
  localparam logic [KIND_W-1:0] OP_APPEND    = 3'd0;
  localparam logic [KIND_W-1:0] OP_FIND      = 3'd1;
  localparam logic [KIND_W-1:0] OP_READ_IDX  = 3'd2;
  localparam logic [KIND_W-1:0] OP_READ_LAST = 3'd3;
  localparam logic [KIND_W-1:0] OP_REMOVE    = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  // Operation broadcast to every cell of the row
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
    logic [INDEX_W-1:0] index;
  } okvt_ctl_t;

endpackage

@@ sv/okvt_if.sv @@
// Valid/ready channel interfaces for operations in and results out.
interface okvt_in_if;
  logic                          valid;
  logic                          ready;
  logic [okvt_pkg::KIND_W-1:0]   kind;
  logic [okvt_pkg::KEY_W-1:0]    key;
  logic [okvt_pkg::VALUE_W-1:0]  value;
  logic [okvt_pkg::INDEX_W-1:0]  index;

  modport source (output valid, kind, key, value, index, input ready);
  modport sink   (input valid, kind, key, value, index, output ready);
endinterface

interface okvt_out_if;
  logic                          valid;
  logic                          ready;
  logic [okvt_pkg::STATUS_W-1:0] status;
  logic [okvt_pkg::KEY_W-1:0]    found_key;
  logic [okvt_pkg::VALUE_W-1:0]  found_value;
  logic [okvt_pkg::POS_W-1:0]    position;
  logic [okvt_pkg::COUNT_W-1:0]  entry_count;

  modport source (output valid, status, found_key, found_value, position, entry_count,
                  input ready);
  modport sink   (input valid, status, found_key, found_value, position, entry_count,
                  output ready);
endinterface

@@ sv/okvt_cell.sv @@
// One table slot: holds a key/value pair, matches it, shifts it on removal.
module okvt_cell #(
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32,
  parameter int CNT_W      = 5,
  parameter int CELL_IDX   = 0
) (
  input  logic                  clk,
  input  logic                  go,
  input  okvt_pkg::okvt_ctl_t   ctl,
  input  logic [CNT_W-1:0]      cnt,
  input  logic                  hit_in,
  input  logic [KEY_BITS-1:0]   nxt_key,
  input  logic [VALUE_BITS-1:0] nxt_val,
  output logic                  hit_out,
  output logic                  sel,
  output logic [KEY_BITS-1:0]   key_q,
  output logic [VALUE_BITS-1:0] val_q
);
  import okvt_pkg::*;

  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic                  occupied;
  logic                  key_eq;
  logic                  cand;

  assign occupied = CELL_IDX < int'(cnt);
  assign key_eq   = key_r == KEY_BITS'(ctl.key);

  always_comb begin
    unique case (ctl.kind)
      OP_FIND, OP_REMOVE: cand = occupied && key_eq;
      OP_READ_IDX:        cand = occupied && (int'(ctl.index) == CELL_IDX);
      OP_READ_LAST:       cand = int'(cnt) == CELL_IDX + 1;
      default:            cand = 1'b0;
    endcase
  end

  // first hit along the row wins
  assign sel     = cand && !hit_in;
  assign hit_out = hit_in || cand;

  always_ff @(posedge clk) begin
    if (go) begin
      if (ctl.kind == OP_APPEND && int'(cnt) == CELL_IDX) begin
        key_r <= KEY_BITS'(ctl.key);
        val_r <= VALUE_BITS'(ctl.value);
      end else if (ctl.kind == OP_REMOVE && hit_out) begin
        key_r <= nxt_key;
        val_r <= nxt_val;
      end
    end
  end

  assign key_q = key_r;
  assign val_q = val_r;

endmodule

@@ sv/ordered_key_value_table.sv @@
// Ordered key/value table: top level with the cell row and the result register.
// The table keeps up to DEPTH key/value entries in insertion order in a row of
// cells; each cell compares its own key against the operation, a first-hit chain
// across the row picks the lowest matching position, and a removal shifts every
// later cell down by one in the same cycle. An operation is accepted whenever
// the result register is empty or being drained, and its result appears on the
// output channel in the following cycle, so one operation per cycle is sustained
// while the output channel is ready. The path that sets the clock is the key
// compare plus the hit chain across all DEPTH cells. Storage needs no clearing
// after reset; only the entry count and the output valid flag are reset.
module ordered_key_value_table #(
  parameter int DEPTH      = 16,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input logic        clk,
  input logic        rst_n,
  okvt_in_if.sink    in_chan,
  okvt_out_if.source out_chan
);
  import okvt_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  okvt_ctl_t             ctl;
  logic                  go;
  logic [CNT_W-1:0]      cnt_r;
  logic [CNT_W-1:0]      cnt_nxt;
  logic [DEPTH:0]        hit_chain;
  logic [DEPTH-1:0]      sel_vec;
  logic [KEY_BITS-1:0]   cell_key [DEPTH];
  logic [VALUE_BITS-1:0] cell_val [DEPTH];
  logic                  any_hit;
  logic                  full;

  logic [KEY_BITS-1:0]   hit_key;
  logic [VALUE_BITS-1:0] hit_val;
  logic [POS_W-1:0]      hit_pos;

  logic                  out_valid_r;
  logic [STATUS_W-1:0]   status_r,  status_nxt;
  logic [KEY_W-1:0]      fkey_r,    fkey_nxt;
  logic [VALUE_W-1:0]    fval_r,    fval_nxt;
  logic [POS_W-1:0]      pos_r,     pos_nxt;
  logic [COUNT_W-1:0]    ecnt_r;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign go            = in_chan.valid && in_chan.ready;

  assign ctl.kind  = in_chan.kind;
  assign ctl.key   = in_chan.key;
  assign ctl.value = in_chan.value;
  assign ctl.index = in_chan.index;

  assign hit_chain[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_BITS-1:0]   up_key;
    logic [VALUE_BITS-1:0] up_val;
    // top cell shifts in its own content; it falls outside the count anyway
    if (i == DEPTH - 1) begin : g_top
      assign up_key = cell_key[i];
      assign up_val = cell_val[i];
    end else begin : g_mid
      assign up_key = cell_key[i+1];
      assign up_val = cell_val[i+1];
    end

    okvt_cell #(
      .KEY_BITS  (KEY_BITS),
      .VALUE_BITS(VALUE_BITS),
      .CNT_W     (CNT_W),
      .CELL_IDX  (i)
    ) u_cell (
      .clk    (clk),
      .go     (go),
      .ctl    (ctl),
      .cnt    (cnt_r),
      .hit_in (hit_chain[i]),
      .nxt_key(up_key),
      .nxt_val(up_val),
      .hit_out(hit_chain[i+1]),
      .sel    (sel_vec[i]),
      .key_q  (cell_key[i]),
      .val_q  (cell_val[i])
    );
  end

  assign any_hit = hit_chain[DEPTH];
  assign full    = int'(cnt_r) >= DEPTH;

  // one-hot select, so OR-ing the gated cells yields the hit entry
  always_comb begin
    hit_key = '0;
    hit_val = '0;
    hit_pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (sel_vec[i]) begin
        hit_key = hit_key | cell_key[i];
        hit_val = hit_val | cell_val[i];
        hit_pos = hit_pos | POS_W'(i);
      end
    end
  end

  always_comb begin
    cnt_nxt    = cnt_r;
    status_nxt = ST_MISS;
    fkey_nxt   = '0;
    fval_nxt   = '0;
    pos_nxt    = '0;
    unique case (in_chan.kind)
      OP_APPEND: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          status_nxt = ST_OK;
          pos_nxt    = POS_W'(cnt_r);
          cnt_nxt    = cnt_r + CNT_W'(1);
        end
      end
      OP_FIND, OP_READ_IDX, OP_READ_LAST, OP_REMOVE: begin
        if (any_hit) begin
          status_nxt = ST_OK;
          fkey_nxt   = KEY_W'(hit_key);
          fval_nxt   = VALUE_W'(hit_val);
          pos_nxt    = hit_pos;
          if (in_chan.kind == OP_REMOVE) begin
            cnt_nxt = cnt_r - CNT_W'(1);
          end
        end
      end
      default: begin
        status_nxt = ST_MISS;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (go) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      status_r <= status_nxt;
      fkey_r   <= fkey_nxt;
      fval_r   <= fval_nxt;
      pos_r    <= pos_nxt;
      ecnt_r   <= COUNT_W'(cnt_nxt);
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = status_r;
  assign out_chan.found_key   = fkey_r;
  assign out_chan.found_value = fval_r;
  assign out_chan.position    = pos_r;
  assign out_chan.entry_count = ecnt_r;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(cnt_r) <= DEPTH)
    else $error("entry count beyond depth");

  a_sel_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(sel_vec))
    else $error("more than one cell selected");

  a_remove_dec: assert property (@(posedge clk) disable iff (!rst_n)
    go && in_chan.kind == OP_REMOVE && any_hit |=> cnt_r == $past(cnt_r) - CNT_W'(1))
    else $error("removal did not drop the count");

  a_append_full: assert property (@(posedge clk) disable iff (!rst_n)
    go && in_chan.kind == OP_APPEND && full |=> $stable(cnt_r) && status_r == ST_FULL)
    else $error("append to full table changed state");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_chan.ready)
    else $error("input stalled with empty result register");
`endif

endmodule
